// ===== hdl/idps_pkg.sv =====
// Shared types and constants for the iterative deepening path search block.
package idps_pkg;
	localparam int NODES_DEF = 16;
	localparam int DEPTH_MAX_DEF = 15;
	localparam int ROW_W = 16;
	localparam int NODE_W = 4;
	localparam int LIM_W = 4;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_POP,
		ST_SCAN,
		ST_TRACE,
		ST_EMIT,
		ST_NONE
	} idps_state_t;

	typedef struct packed {
		logic start_limit;
		logic next_limit;
		logic clear_step;
		logic pop;
		logic scan_step;
		logic trace_start;
		logic trace_step;
		logic emit_step;
	} idps_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic stack_empty;
		logic hit;
		logic can_expand;
		logic scan_done;
		logic trace_done;
		logic emit_last;
		logic limit_done;
		logic bad_node;
	} idps_sts_t;
endpackage

// ===== hdl/idps_if.sv =====
// Valid/ready channel interfaces for input items and result items.
interface idps_in_if;
	logic valid;
	logic ready;
	logic kind;
	logic [3:0] row_index;
	logic [15:0] row_edges;
	logic [3:0] source_node;
	logic [3:0] target;
	logic [3:0] depth_limit;
	modport source (output valid, kind, row_index, row_edges, source_node, target, depth_limit,
		input ready);
	modport sink (input valid, kind, row_index, row_edges, source_node, target, depth_limit,
		output ready);
endinterface

interface idps_out_if;
	logic valid;
	logic ready;
	logic found;
	logic [3:0] node;
	logic last;
	modport source (output valid, found, node, last, input ready);
	modport sink (input valid, found, node, last, output ready);
endinterface

// ===== hdl/idps_datapath.sv =====
// Datapath: adjacency, stack, visited marks, parents, path trace.
module idps_datapath import idps_pkg::*; #(
	parameter int NODES = NODES_DEF,
	parameter int DEPTH_MAX = DEPTH_MAX_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic load_en,
	input  logic [3:0] load_row,
	input  logic [15:0] load_edges,
	input  logic search_start,
	input  logic [3:0] in_src,
	input  logic [3:0] in_dst,
	input  logic [3:0] in_lim,
	input  idps_cmd_t cmd,
	output idps_sts_t sts,
	output logic [3:0] emit_node
);
	localparam int LEVELS = DEPTH_MAX + 1;
	localparam int PAIRS = NODES * LEVELS;
	localparam int NI_W = $clog2(NODES);
	localparam int DI_W = $clog2(LEVELS + 1);
	localparam int LV_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int SP_W = $clog2(PAIRS + 1);
	localparam int PA_W = $clog2(PAIRS);

	logic [ROW_W-1:0] adj_q [NODES];
	logic [NODES-1:0] vis_q [LEVELS];
	logic [NI_W-1:0] stk_node_q [PAIRS];
	logic [DI_W-1:0] stk_dep_q [PAIRS];
	logic [NI_W-1:0] par_q [PAIRS];
	logic [NI_W-1:0] path_q [LEVELS];

	logic [SP_W-1:0] top_q;
	logic [NI_W-1:0] src_q, dst_q, u_q;
	logic [DI_W-1:0] d_q, lim_q, maxd_q, k_q, len_q, ei_q;
	logic [NI_W:0] v_q;
	logic [LV_W-1:0] clr_q;
	logic [NI_W-1:0] x_q;
	logic bad_q;

	logic [PA_W-1:0] stk_ra;
	logic [PA_W-1:0] par_ra;
	logic stk_we;
	logic [PA_W-1:0] stk_wa;
	logic [NI_W-1:0] stk_wn;
	logic [DI_W-1:0] stk_wd;
	logic [NI_W-1:0] vi;
	logic [LV_W-1:0] d1;
	logic push;

	assign stk_ra = PA_W'(top_q - SP_W'(1));
	assign par_ra = PA_W'(32'(x_q) * LEVELS + 32'(k_q));
	assign vi = NI_W'(v_q - (NI_W+1)'(1));
	assign d1 = LV_W'(d_q + DI_W'(1));
	assign push = cmd.scan_step && (v_q != '0) && (32'(vi) < ROW_W) && adj_q[u_q][vi]
		&& !vis_q[d1][vi] && (32'(top_q) < PAIRS);
	// one stack write port: seed of the source at slot zero, or a push
	assign stk_we = push || (cmd.clear_step && clr_q == '0);
	assign stk_wa = push ? PA_W'(top_q) : '0;
	assign stk_wn = push ? vi : src_q;
	assign stk_wd = push ? DI_W'(d1) : '0;

	always_ff @(posedge clk) begin
		if (load_en && 32'(load_row) < NODES)
			adj_q[NI_W'(load_row)] <= load_edges;
		if (stk_we) begin
			stk_node_q[stk_wa] <= stk_wn;
			stk_dep_q[stk_wa] <= stk_wd;
		end
		if (push)
			par_q[PA_W'(32'(vi) * LEVELS + 32'(d1))] <= u_q;
		// synchronous reads of the popped pair and of the parent
		if (cmd.pop) begin
			u_q <= stk_node_q[stk_ra];
			d_q <= stk_dep_q[stk_ra];
		end
		if (cmd.trace_start)
			x_q <= u_q;
		if (cmd.trace_step) begin
			path_q[LV_W'(k_q)] <= x_q;
			if (k_q != '0)
				x_q <= par_q[par_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0; src_q <= '0; dst_q <= '0;
			lim_q <= '0; maxd_q <= '0; k_q <= '0; len_q <= '0; ei_q <= '0;
			v_q <= '0; clr_q <= '0; bad_q <= 1'b0;
			for (int i = 0; i < LEVELS; i++) vis_q[i] <= '0;
		end else begin
			if (search_start) begin
				src_q <= NI_W'(in_src);
				dst_q <= NI_W'(in_dst);
				bad_q <= (32'(in_src) >= NODES) || (32'(in_dst) >= NODES);
				maxd_q <= (32'(in_lim) > DEPTH_MAX) ? DI_W'(DEPTH_MAX) : DI_W'(in_lim);
				lim_q <= '0;
				clr_q <= '0;
			end
			if (cmd.next_limit) lim_q <= lim_q + DI_W'(1);
			if (cmd.start_limit) clr_q <= '0;
			if (cmd.clear_step) begin
				vis_q[clr_q] <= (clr_q == '0) ? (NODES'(1) << src_q) : '0;
				clr_q <= clr_q + LV_W'(1);
				if (clr_q == '0) begin
					top_q <= SP_W'(1);
				end
			end
			if (cmd.pop) begin
				top_q <= top_q - SP_W'(1);
				v_q <= (NI_W+1)'(NODES);
			end
			if (cmd.scan_step) begin
				v_q <= v_q - (NI_W+1)'(1);
				if (push) begin
					vis_q[d1][vi] <= 1'b1;
					top_q <= top_q + SP_W'(1);
				end
			end
			if (cmd.trace_start) begin
				k_q <= d_q; len_q <= d_q + DI_W'(1); ei_q <= '0;
			end
			if (cmd.trace_step && k_q != '0)
				k_q <= k_q - DI_W'(1);
			if (cmd.emit_step) ei_q <= ei_q + DI_W'(1);
		end
	end

	always_comb begin
		sts.clear_done = (32'(clr_q) == LEVELS - 1);
		sts.stack_empty = (top_q == '0);
		sts.hit = (u_q == dst_q);
		sts.can_expand = (d_q < lim_q);
		sts.scan_done = (v_q == '0);
		sts.trace_done = (k_q == '0);
		sts.emit_last = (ei_q + DI_W'(1) == len_q);
		sts.limit_done = (lim_q >= maxd_q);
		sts.bad_node = bad_q;
	end
	assign emit_node = 4'(path_q[LV_W'(ei_q)]);
endmodule

// ===== hdl/idps_ctrl.sv =====
// Controller state machine for the search sequence and result handshake.
module idps_ctrl import idps_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_kind,
	output logic in_ready,
	output logic search_start,
	output logic out_valid,
	input  logic out_ready,
	output logic out_found,
	output logic out_last,
	output idps_cmd_t cmd,
	input  idps_sts_t sts
);
	idps_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		search_start = 1'b0;
		out_valid = 1'b0;
		out_found = 1'b0;
		out_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && in_kind == KIND_SEARCH) begin
					search_start = 1'b1;
					state_d = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				if (sts.bad_node) state_d = ST_NONE;
				else begin
					cmd.clear_step = 1'b1;
					if (sts.clear_done) state_d = ST_POP;
				end
			end
			ST_POP: begin
				if (sts.stack_empty) begin
					if (sts.limit_done) state_d = ST_NONE;
					else begin
						cmd.next_limit = 1'b1;
						cmd.start_limit = 1'b1;
						state_d = ST_CLEAR;
					end
				end else begin
					cmd.pop = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.hit) begin
					cmd.trace_start = 1'b1;
					state_d = ST_TRACE;
				end else if (!sts.can_expand || sts.scan_done) state_d = ST_POP;
				else cmd.scan_step = 1'b1;
			end
			ST_TRACE: begin
				// each cycle stores one path node; the source at depth zero ends it
				cmd.trace_step = 1'b1;
				if (sts.trace_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				out_found = 1'b1;
				out_last = sts.emit_last;
				if (out_ready) begin
					cmd.emit_step = 1'b1;
					if (sts.emit_last) state_d = ST_IDLE;
				end
			end
			ST_NONE: begin
				out_valid = 1'b1;
				out_last = 1'b1;
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ===== hdl/iterative_deepening_path_search_top.sv =====
// Top level of the iterative deepening path search block.
//  channel  dir  fields                                                   notes
//  in_ch    in   kind,row_index,row_edges,source_node,target,depth_limit  row load or search
//  out_ch   out  found,node,last                                          one transfer per path node, or one if no path
// A search holds input off until its last result transfers.
// Per limit: clear the visited marks level by level, then per popped node one pop and a
// scan of its adjacency row; then trace the path back and emit one result per path node.
// The single-step scan of each adjacency row dominates the search time.
// Reset clears control state and the visited marks; the other stores are undefined until written.
// A stalled result holds the controller in its emit or no-path state.
module iterative_deepening_path_search_top import idps_pkg::*; #(
	parameter int NODES = NODES_DEF,
	parameter int DEPTH_MAX = DEPTH_MAX_DEF
) (
	input logic clk,
	input logic arst_n,
	idps_in_if.sink in_ch,
	idps_out_if.source out_ch
);
	idps_cmd_t cmd;
	idps_sts_t sts;
	logic search_start;
	logic [3:0] emit_node;
	logic out_found;

	idps_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_kind(in_ch.kind), .in_ready(in_ch.ready),
		.search_start,
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_found, .out_last(out_ch.last),
		.cmd, .sts
	);

	idps_datapath #(.NODES(NODES), .DEPTH_MAX(DEPTH_MAX)) u_dp (
		.clk, .arst_n,
		// row loads commit the cycle they transfer
		.load_en(in_ch.valid && in_ch.ready && in_ch.kind == KIND_LOAD),
		.load_row(in_ch.row_index), .load_edges(in_ch.row_edges),
		.search_start,
		.in_src(in_ch.source_node), .in_dst(in_ch.target), .in_lim(in_ch.depth_limit),
		.cmd, .sts, .emit_node
	);

	assign out_ch.found = out_found;
	// node reads zero on the no-path result
	assign out_ch.node = out_found ? emit_node : 4'd0;
endmodule

// ===== hdl/idps_checker.sv =====
// Port-level checker for the search block, bound to the top level.
module idps_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_found,
	input logic out_last,
	input logic [3:0] out_node
);
	a_no_accept_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input ready during result");
	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_found) |-> (out_last && out_node == 4'd0))
		else $error("no-path result malformed");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_found)))
		else $error("result dropped while stalled");
	a_ready_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_last) |=> in_ready)
		else $error("not idle after last result");
endmodule

bind iterative_deepening_path_search_top idps_checker u_chk (
	.clk, .arst_n,
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_found(out_ch.found), .out_last(out_ch.last), .out_node(out_ch.node)
);

// ===== tb/idps_tb_pkg.sv =====
// Testbench-side item types for the path search bench.
package idps_tb_pkg;
	typedef struct {
		logic found;
		logic [3:0] node;
		logic last;
	} path_step_t;
endpackage

// ===== tb/idps_checker.sv =====
// Path predictor and result checker watching both channels of the search block.
module idps_scoreboard import idps_pkg::*; import idps_tb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_kind,
	input logic [3:0] in_row_index,
	input logic [15:0] in_row_edges,
	input logic [3:0] in_source,
	input logic [3:0] in_target,
	input logic [3:0] in_depth_limit,
	input logic out_valid,
	input logic out_ready,
	input logic out_found,
	input logic [3:0] out_node,
	input logic out_last,
	output int fail_count,
	output int pending_steps,
	output int searches_done,
	output int paths_found
);
	localparam int LEVELS = DEPTH_MAX_DEF + 1;

	logic [15:0] graph_rows [NODES_DEF];
	path_step_t expected_steps [$];

	// one depth-limited walk; fills route and returns its length, 0 if none
	function automatic int walk_limited(input int src, input int dst, input int lim,
		ref logic [3:0] route [LEVELS]);
		logic [3:0] stk_node [NODES_DEF * LEVELS];
		int stk_depth [NODES_DEF * LEVELS];
		logic [15:0] seen [LEVELS];
		logic [3:0] par [NODES_DEF][LEVELS];
		int sp;
		int u;
		int d;
		int x;
		int k;
		for (int i = 0; i < LEVELS; i++) seen[i] = '0;
		stk_node[0] = src[3:0];
		stk_depth[0] = 0;
		sp = 1;
		seen[0][src] = 1'b1;
		while (sp > 0) begin
			sp--;
			u = stk_node[sp];
			d = stk_depth[sp];
			if (u == dst) begin
				x = u;
				k = d;
				forever begin
					route[k] = x[3:0];
					if (k == 0) break;
					x = par[x][k];
					k--;
				end
				return d + 1;
			end
			if (d < lim) begin
				for (int v = NODES_DEF - 1; v >= 0; v--) begin
					if (graph_rows[u][v] && !seen[d + 1][v] && sp < NODES_DEF * LEVELS) begin
						seen[d + 1][v] = 1'b1;
						par[v][d + 1] = u[3:0];
						stk_node[sp] = v[3:0];
						stk_depth[sp] = d + 1;
						sp++;
					end
				end
			end
		end
		return 0;
	endfunction

	task automatic predict_search(input int src, input int dst, input int maxd);
		logic [3:0] route [LEVELS];
		int len;
		path_step_t s;
		len = 0;
		if (maxd > DEPTH_MAX_DEF) maxd = DEPTH_MAX_DEF;
		for (int lim = 0; lim <= maxd && len == 0; lim++)
			len = walk_limited(src, dst, lim, route);
		if (len == 0) begin
			s.found = 1'b0;
			s.node = '0;
			s.last = 1'b1;
			expected_steps = {expected_steps, s};
		end else begin
			paths_found++;
			for (int i = 0; i < len; i++) begin
				s.found = 1'b1;
				s.node = route[i];
				s.last = (i == len - 1);
				expected_steps = {expected_steps, s};
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		path_step_t e;
		if (!arst_n) begin
			fail_count <= 0;
			searches_done <= 0;
			paths_found = 0;
			expected_steps.delete();
			for (int i = 0; i < NODES_DEF; i++) graph_rows[i] = '0;
		end else begin
			if (in_valid && in_ready) begin
				if (in_kind == KIND_LOAD) begin
					graph_rows[in_row_index] = in_row_edges;
				end else begin
					searches_done <= searches_done + 1;
					predict_search(in_source, in_target, in_depth_limit);
				end
			end
			if (out_valid && out_ready) begin
				if (expected_steps.size() == 0) begin
					fail_count <= fail_count + 1;
					$display("%0t: unexpected result found=%0d node=%0d last=%0d",
						$time, out_found, out_node, out_last);
				end else begin
					e = expected_steps.pop_front();
					if (e.found !== out_found || e.node !== out_node || e.last !== out_last) begin
						fail_count <= fail_count + 1;
						$display("%0t: expected found=%0d node=%0d last=%0d, got %0d %0d %0d",
							$time, e.found, e.node, e.last, out_found, out_node, out_last);
					end
				end
			end
		end
		pending_steps = expected_steps.size();
	end
endmodule

// ===== tb/tb_iterative_deepening_path_search_top.sv =====
// Stimulus and verdict for the iterative deepening path search block.
module tb_iterative_deepening_path_search_top;
	import idps_pkg::*;

	logic clk;
	logic arst_n;
	int fail_count;
	int pending_steps;
	int searches_done;
	int paths_found;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_off;
	int items_sent;

	idps_in_if in_ch();
	idps_out_if out_ch();

	iterative_deepening_path_search_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	idps_scoreboard chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_kind(in_ch.kind),
		.in_row_index(in_ch.row_index), .in_row_edges(in_ch.row_edges),
		.in_source(in_ch.source_node), .in_target(in_ch.target),
		.in_depth_limit(in_ch.depth_limit),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_found(out_ch.found),
		.out_node(out_ch.node), .out_last(out_ch.last),
		.fail_count(fail_count), .pending_steps(pending_steps),
		.searches_done(searches_done), .paths_found(paths_found)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver: random stalls, plus a long hold-off when requested.
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) out_ch.ready <= 1'b0;
			else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Pressure: once 200 items are sent, the receiver stops while the sender keeps offering items.
	initial begin
		hold_off = 1'b0;
		wait (items_sent == 200);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (300) @(posedge clk);
		hold_off = 1'b0;
	end

	// Drive one transfer; random idle cycles go in front of it.
	task automatic send_item(input logic k, input logic [3:0] ri, input logic [15:0] re,
		input logic [3:0] s, input logic [3:0] t, input logic [3:0] dl);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= k;
		in_ch.row_index <= ri;
		in_ch.row_edges <= re;
		in_ch.source_node <= s;
		in_ch.target <= t;
		in_ch.depth_limit <= dl;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic load_row(input logic [3:0] r, input logic [15:0] e);
		send_item(KIND_LOAD, r, e, 4'($urandom), 4'($urandom), 4'($urandom));
	endtask

	task automatic search(input logic [3:0] s, input logic [3:0] t, input logic [3:0] dl);
		send_item(KIND_SEARCH, 4'($urandom), 16'($urandom), s, t, dl);
	endtask

	// Random graph; sparse rows keep paths long enough to be interesting.
	task automatic load_graph(input int density);
		logic [15:0] e;
		for (int r = 0; r < 16; r++) begin
			e = '0;
			for (int v = 0; v < 16; v++) e[v] = ($urandom_range(99) < density);
			load_row(r[3:0], e);
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.kind = KIND_LOAD;
		in_ch.row_index = '0;
		in_ch.row_edges = '0;
		in_ch.source_node = '0;
		in_ch.target = '0;
		in_ch.depth_limit = '0;
		items_sent = 0;
		send_idle_pct = 19;
		recv_idle_pct = 77;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every row written first so no search reads an unloaded row.
		// Chain 0->1->...->14 plus a shortcut 0->8, full row on 15, empty row 14.
		for (int r = 0; r < 16; r++)
			load_row(r[3:0], (r == 15) ? 16'hFFFF : (r == 14) ? 16'h0000 :
				(r == 0) ? 16'h0102 : (16'h1 << (r + 1)));
		search(4'd0, 4'd0, 4'd0);    // source equals target
		search(4'd0, 4'd15, 4'd15);  // target unreachable, no path
		search(4'd1, 4'd13, 4'd15);  // long chain
		search(4'd1, 4'd13, 4'd3);   // limit too small: no path
		search(4'd14, 4'd3, 4'd15);  // dead end
		search(4'd15, 4'd7, 4'd0);   // limit zero, no path
		search(4'd15, 4'd7, 4'd1);   // full row
		search(4'd2, 4'd15, 4'd15);
		load_row(4'd14, 16'hFFFF);
		search(4'd14, 4'd0, 4'd1);

		// Random phases with different idle patterns.
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				send_idle_pct = 77;
				recv_idle_pct = 19;
			end else if (ph == 2) begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
			end
			for (int g = 0; g < 3; g++) begin
				load_graph((g == 0) ? 12 : (g == 1) ? 25 : 50);
				for (int i = 0; i < 16; i++) begin
					if ($urandom_range(9) == 0)
						load_row(4'($urandom), 16'($urandom));
					search(4'($urandom), 4'($urandom), 4'($urandom));
				end
			end
		end
		in_ch.valid <= 1'b0;

		// let the predictor see the last transfer before waiting on it
		@(posedge clk);
		while (pending_steps != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Covered %0d input transfers, %0d searches, %0d with a path found.",
			items_sent, searches_done, paths_found);
		if (fail_count == 0 && pending_steps == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Worst search: 16 limits, each clearing the visited marks and scanning a row per pop;
	// 153 searches at that bound plus stalls stay well below this timeout.
	initial begin
		#500000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ===== filelist.f =====
hdl/idps_pkg.sv
hdl/idps_if.sv
hdl/idps_datapath.sv
hdl/idps_ctrl.sv
hdl/iterative_deepening_path_search_top.sv
hdl/idps_checker.sv
tb/idps_tb_pkg.sv
tb/idps_checker.sv
tb/tb_iterative_deepening_path_search_top.sv
